// ===== hdl/rsht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Ray segment hit time package
// Widths, register indexes and pipeline payload types shared by the block.
// ----------------------------------------------------------------------------
package rsht_pkg;

    localparam int CW    = 32;
    localparam int FB    = 16;
    localparam int DW    = CW + 1;
    localparam int QB    = CW - 1;
    localparam int PW    = DW + QB;
    localparam int MW    = PW - FB;
    localparam int WW    = MW + 3;
    localparam int TW    = FB + 1;
    localparam int XW    = DW + 2;
    localparam int TOL_W = 16;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SEG_START_X     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_START_Y     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_END_X       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_END_Y       = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_ENABLED     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_ZERO_TOL   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH_TOL   = CFG_IDX_W'(6);

    localparam logic [TOL_W-1:0] NEAR_ZERO_TOL_RST = TOL_W'(1);
    localparam logic [TOL_W-1:0] MIN_WIDTH_TOL_RST = TOL_W'(7);

    localparam logic [TW-1:0] T_ONE = {1'b1, {FB{1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] rsx;
        logic signed [CW-1:0] rsy;
        logic signed [DW-1:0] rdx;
        logic signed [DW-1:0] rdy;
        logic [DW-1:0]        ma;
        logic                 an;
        logic [DW-1:0]        mrdx;
        logic                 rej;
    } t_ray;

    typedef struct packed {
        logic signed [CW-1:0] rsx;
        logic                 rdxn;
        logic [DW-1:0]        mrdx;
        logic                 miss;
        logic                 zhit;
    } t_tc;

endpackage
`default_nettype wire

// ===== hdl/ray_segment_hit_time.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Ray segment hit time
// Tests a stream of 2D ray segments against one configured floor segment and
// returns a hit flag and the hit time in Q1.16.
//
// The input channel takes one ray per transfer (i_valid high, o_stall low).
// The output channel offers one result per ray on o_valid; the receiver holds
// it with i_stall. One ray can be taken every cycle while o_stall is low.
// The pipeline is the slope divider (one quotient bit per stage, 31 stages)
// and the time divider (17 stages) plus the entry, multiply, compare and
// output stages.
// All stages advance together. While an offered result is stalled the whole
// pipeline holds and o_stall is high; nothing is dropped or repeated.
// The user must write the segment registers through the plain write port only
// while no ray is in flight; the block does not enforce this. Reset clears the
// pipeline valid bits and loads the register defaults (segment disabled).
// ----------------------------------------------------------------------------
module ray_segment_hit_time import rsht_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CW-1:0]        i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_ray_start_x,
    input  logic signed [CW-1:0] i_ray_start_y,
    input  logic signed [CW-1:0] i_ray_end_x,
    input  logic signed [CW-1:0] i_ray_end_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic [TW-1:0]        o_hit_time
);

    logic signed [CW-1:0] r_seg_start_x, r_seg_start_y, r_seg_end_x, r_seg_end_y;
    logic                 r_seg_enabled;
    logic [TOL_W-1:0]     r_near_zero_tol, r_min_width_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_start_x   <= '0;
            r_seg_start_y   <= '0;
            r_seg_end_x     <= '0;
            r_seg_end_y     <= '0;
            r_seg_enabled   <= 1'b0;
            r_near_zero_tol <= NEAR_ZERO_TOL_RST;
            r_min_width_tol <= MIN_WIDTH_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEG_START_X:   r_seg_start_x   <= i_cfg_data;
                CFG_SEG_START_Y:   r_seg_start_y   <= i_cfg_data;
                CFG_SEG_END_X:     r_seg_end_x     <= i_cfg_data;
                CFG_SEG_END_Y:     r_seg_end_y     <= i_cfg_data;
                CFG_SEG_ENABLED:   r_seg_enabled   <= i_cfg_data[0];
                CFG_NEAR_ZERO_TOL: r_near_zero_tol <= i_cfg_data[TOL_W-1:0];
                CFG_MIN_WIDTH_TOL: r_min_width_tol <= i_cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic                 r_ovld;
    logic                 n_adv;

    assign n_adv   = !r_ovld || !i_stall;
    assign o_stall = !n_adv;
    assign o_valid = r_ovld;

    // Segment geometry, taken straight from the registers.
    logic signed [DW-1:0] n_sdx, n_sdy;
    logic [DW-1:0]        n_sdx_mag, n_sdy_mag;
    logic signed [CW-1:0] n_minx, n_maxx;
    logic                 n_rej, n_sat, n_sneg;

    assign n_sdx     = DW'(r_seg_end_x) - DW'(r_seg_start_x);
    assign n_sdy     = DW'(r_seg_end_y) - DW'(r_seg_start_y);
    assign n_sdx_mag = n_sdx[DW-1] ? DW'(-n_sdx) : DW'(n_sdx);
    assign n_sdy_mag = n_sdy[DW-1] ? DW'(-n_sdy) : DW'(n_sdy);
    assign n_minx    = (r_seg_start_x < r_seg_end_x) ? r_seg_start_x : r_seg_end_x;
    assign n_maxx    = (r_seg_start_x < r_seg_end_x) ? r_seg_end_x : r_seg_start_x;
    assign n_rej     = !r_seg_enabled || (n_sdx_mag <= DW'(r_min_width_tol));
    assign n_sat     = (n_sdy_mag >> (QB - FB)) >= n_sdx_mag;
    assign n_sneg    = n_sdx[DW-1] ^ n_sdy[DW-1];

    // Entry stage.
    logic signed [DW-1:0] n_rdx, n_rdy, n_a1;
    t_ray                 n_ray;

    assign n_rdx = DW'(i_ray_end_x) - DW'(i_ray_start_x);
    assign n_rdy = DW'(i_ray_end_y) - DW'(i_ray_start_y);
    assign n_a1  = DW'(i_ray_start_x) - DW'(r_seg_start_x);

    always_comb begin
        n_ray.rsx  = i_ray_start_x;
        n_ray.rsy  = i_ray_start_y;
        n_ray.rdx  = n_rdx;
        n_ray.rdy  = n_rdy;
        n_ray.ma   = n_a1[DW-1] ? DW'(-n_a1) : DW'(n_a1);
        n_ray.an   = n_a1[DW-1];
        n_ray.mrdx = n_rdx[DW-1] ? DW'(-n_rdx) : DW'(n_rdx);
        n_ray.rej  = n_rej;
    end

    // Slope divider: one quotient bit per stage.
    t_ray              r_sray [QB+1];
    logic [DW-1:0]     r_srem [QB+1];
    logic [DW-1:0]     r_sden [QB+1];
    logic [QB-FB-1:0]  r_snlo [QB+1];
    logic [QB-1:0]     r_squo [QB+1];
    logic              r_ssat [QB+1];
    logic              r_sneg [QB+1];
    logic              r_sv   [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (n_adv) begin
            r_sv[0]   <= i_valid;
            r_sray[0] <= n_ray;
            r_srem[0] <= n_sdy_mag >> (QB - FB);
            r_sden[0] <= n_sdx_mag;
            r_snlo[0] <= n_sdy_mag[QB-FB-1:0];
            r_squo[0] <= '0;
            r_ssat[0] <= n_sat;
            r_sneg[0] <= n_sneg;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_sdiv
        localparam int J = QB - 1 - k;
        logic          n_bit;
        logic [DW:0]   n_trial;
        logic          n_ge;

        if (J >= FB) begin : g_bit
            assign n_bit = r_snlo[k][J-FB];
        end else begin : g_zero
            assign n_bit = 1'b0;
        end

        assign n_trial = {r_srem[k], n_bit};
        assign n_ge    = n_trial >= {1'b0, r_sden[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (n_adv) begin
                r_sv[k+1]   <= r_sv[k];
                r_sray[k+1] <= r_sray[k];
                r_srem[k+1] <= n_ge ? DW'(n_trial - {1'b0, r_sden[k]}) : DW'(n_trial);
                r_sden[k+1] <= r_sden[k];
                r_snlo[k+1] <= r_snlo[k];
                r_squo[k+1] <= {r_squo[k][QB-2:0], n_ge};
                r_ssat[k+1] <= r_ssat[k];
                r_sneg[k+1] <= r_sneg[k];
            end
        end
    end

    // Products with the slope.
    logic [QB-1:0] n_smag;
    logic [PW-1:0] r_p1, r_p2;
    logic          r_n1, r_n2, r_mv;
    t_ray          r_mray;

    assign n_smag = r_ssat[QB] ? {QB{1'b1}} : r_squo[QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (n_adv) begin
            r_mv   <= r_sv[QB];
            r_mray <= r_sray[QB];
            r_p1   <= {{QB{1'b0}}, r_sray[QB].ma} * {{DW{1'b0}}, n_smag};
            r_p2   <= {{QB{1'b0}}, r_sray[QB].mrdx} * {{DW{1'b0}}, n_smag};
            r_n1   <= r_sray[QB].an ^ r_sneg[QB];
            r_n2   <= r_sray[QB].rdx[DW-1] ^ r_sneg[QB];
        end
    end

    // Distance above the line and rate of approach.
    logic signed [WW-1:0] n_m1, n_m2, n_m1s, n_m2s;
    logic signed [WW-1:0] r_dist, r_appr;
    logic                 r_dv;
    t_ray                 r_dray;

    assign n_m1  = $signed(WW'(r_p1[PW-1:FB]));
    assign n_m2  = $signed(WW'(r_p2[PW-1:FB]));
    assign n_m1s = r_n1 ? -n_m1 : n_m1;
    assign n_m2s = r_n2 ? -n_m2 : n_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (n_adv) begin
            r_dv   <= r_mv;
            r_dray <= r_mray;
            r_dist <= WW'(r_mray.rsy) - WW'(r_seg_start_y) - n_m1s;
            r_appr <= WW'(r_mray.rdy) - n_m2s;
        end
    end

    // Case classification, first half.
    logic [WW-1:0]        n_mdist, n_mappr;
    logic signed [CW-1:0] n_edge;
    logic                 n_rdx_pos;

    logic [WW-1:0]        r_mdist, r_mappr;
    logic signed [DW-1:0] r_num;
    logic                 r_par, r_dsm, r_inspan, r_rxsm, r_sgnmiss, r_cv;
    t_ray                 r_cray;

    assign n_mdist   = r_dist[WW-1] ? WW'(-r_dist) : WW'(r_dist);
    assign n_mappr   = r_appr[WW-1] ? WW'(-r_appr) : WW'(r_appr);
    assign n_rdx_pos = !r_dray.rdx[DW-1] && (r_dray.rdx != '0);
    assign n_edge    = n_rdx_pos ? n_minx : n_maxx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (n_adv) begin
            r_cv      <= r_dv;
            r_cray    <= r_dray;
            r_mdist   <= n_mdist;
            r_mappr   <= n_mappr;
            r_par     <= n_mappr <= WW'(r_near_zero_tol);
            r_dsm     <= n_mdist <= WW'(r_near_zero_tol);
            r_inspan  <= (r_dray.rsx >= n_minx) && (r_dray.rsx <= n_maxx);
            r_rxsm    <= r_dray.mrdx <= DW'(r_near_zero_tol);
            r_num     <= DW'(n_edge) - DW'(r_dray.rsx);
            r_sgnmiss <= (r_dist != '0) && (r_dist[WW-1] == r_appr[WW-1]);
        end
    end

    // Case classification, second half; loads the time divider.
    logic [DW-1:0] n_mnum;
    logic          n_pmiss, n_nmiss;
    t_tc           n_tc;

    assign n_mnum  = r_num[DW-1] ? DW'(-r_num) : DW'(r_num);
    assign n_pmiss = !r_dsm || (!r_inspan && (r_rxsm
                     || ((r_num != '0) && (r_num[DW-1] != r_cray.rdx[DW-1]))
                     || (n_mnum > r_cray.mrdx)));
    assign n_nmiss = r_sgnmiss || (r_mdist > r_mappr);

    always_comb begin
        n_tc.rsx  = r_cray.rsx;
        n_tc.rdxn = r_cray.rdx[DW-1];
        n_tc.mrdx = r_cray.mrdx;
        n_tc.miss = r_cray.rej || (r_par ? n_pmiss : n_nmiss);
        n_tc.zhit = r_par && r_dsm && r_inspan;
    end

    // Time divider: one quotient bit per stage.
    logic [WW-1:0] r_trem [TW+1];
    logic [WW-1:0] r_tden [TW+1];
    logic [TW-1:0] r_tquo [TW+1];
    t_tc           r_tc   [TW+1];
    logic          r_tv   [TW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv[0] <= 1'b0;
        end else if (n_adv) begin
            r_tv[0]   <= r_cv;
            r_tc[0]   <= n_tc;
            r_trem[0] <= r_par ? WW'(n_mnum) : r_mdist;
            r_tden[0] <= r_par ? WW'(r_cray.mrdx) : r_mappr;
            r_tquo[0] <= '0;
        end
    end

    for (genvar k = 0; k < TW; k++) begin : g_tdiv
        logic [WW:0] n_trial;
        logic        n_ge;

        if (k == 0) begin : g_first
            assign n_trial = {1'b0, r_trem[k]};
        end else begin : g_next
            assign n_trial = {r_trem[k], 1'b0};
        end

        assign n_ge = n_trial >= {1'b0, r_tden[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tv[k+1] <= 1'b0;
            end else if (n_adv) begin
                r_tv[k+1]   <= r_tv[k];
                r_tc[k+1]   <= r_tc[k];
                r_trem[k+1] <= n_ge ? WW'(n_trial - {1'b0, r_tden[k]}) : WW'(n_trial);
                r_tden[k+1] <= r_tden[k];
                r_tquo[k+1] <= {r_tquo[k][TW-2:0], n_ge};
            end
        end
    end

    // Hit x product.
    logic [DW+TW-1:0] r_hp;
    logic [TW-1:0]    r_ht;
    t_tc              r_htc;
    logic             r_hv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (n_adv) begin
            r_hv  <= r_tv[TW];
            r_htc <= r_tc[TW];
            r_ht  <= r_tquo[TW];
            r_hp  <= {{TW{1'b0}}, r_tc[TW].mrdx} * {{DW{1'b0}}, r_tquo[TW]};
        end
    end

    // Span check and output register.
    logic signed [XW-1:0] n_sh, n_hx, n_lo, n_hi;
    logic                 n_hit;

    assign n_sh  = $signed(XW'(r_hp[DW+TW-1:FB]));
    assign n_hx  = XW'(r_htc.rsx) + (r_htc.rdxn ? -n_sh : n_sh);
    assign n_lo  = XW'(n_minx) - $signed(XW'(r_near_zero_tol));
    assign n_hi  = XW'(n_maxx) + $signed(XW'(r_near_zero_tol));
    assign n_hit = !r_htc.miss && (r_htc.zhit || ((n_hx >= n_lo) && (n_hx <= n_hi)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (n_adv) begin
            r_ovld     <= r_hv;
            o_hit      <= n_hit;
            o_hit_time <= n_hit ? (r_htc.zhit ? '0 : r_ht) : T_ONE;
        end
    end

endmodule
`default_nettype wire
